// ===== hdl/epcc_pkg.sv =====
// ----------------------------------------------------------------------------
// epcc_pkg
// Shared types and constants of the encoder position cross-check unit.
// ----------------------------------------------------------------------------
package epcc_pkg;

   // Field widths.
   localparam int STAMP_W  = 32;
   localparam int ENC_W    = 32;
   localparam int CMD_W    = 32;
   localparam int SPEED_W  = 16;
   localparam int SCALE_W  = 24;
   localparam int DEV_W    = 32;
   localparam int MAXDEV_W = 31;
   localparam int STREAK_W = 8;

   localparam int POSITION_WIDTH_DEFAULT = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_STILL_POS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_SPD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CPM        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_COUNT = 3'd5;

   localparam logic [15:0] STILL_POS_RESET  = 16'd50;
   localparam logic [15:0] STILL_SPD_RESET  = 16'd48;
   localparam logic [19:0] DETECT_RESET     = 20'd8000;
   localparam logic [23:0] CPM_RESET        = 24'd25600;
   localparam logic [19:0] DEV_LIMIT_RESET  = 20'd1000;
   localparam logic [7:0]  WARN_COUNT_RESET = 8'd3;

   // Encoder counts are turned into micrometres-times-Q8 by this factor.
   localparam int              MM_FACTOR_W = 18;
   localparam logic [17:0]     MM_FACTOR   = 18'd256000;
   // |count difference| * 256000 stays below 2^49.
   localparam int              NUM_W       = 49;

   localparam logic [SCALE_W-1:0]  SCALE_MAX  = '1;
   localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

   typedef enum logic [1:0] {
      PH_AWAIT   = 2'd0,
      PH_MEASURE = 2'd1,
      PH_TRACK   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCALE,
      ST_DIV,
      ST_FINISH,
      ST_STILL,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/encoder_position_cross_check_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_position_cross_check_unit
// Checks drive encoder counts against the commanded axis position: finds a
// standstill reference, measures direction and scale, then tracks deviation
// and latches a lost-steps warning.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req_     in         tuser: homed, encoder_valid; tdata: stamp, count, pos, speed
//  rsp_     out        tuser: accepted; tdata: phase .. lost_steps_warn
//  csr_     in         register write: index 0..5, data up to 24 bits
//
//  A scale measurement or a deviation runs the shared restoring divider, one
//  quotient bit a cycle, over the NUM_W (49) bit numerator.
//  One beat is in work at a time; the next is taken while a result still
//  waits in the output register, and the unit stalls at the end if it does.
//  Reset (synchronous) clears all tracking state and loads register defaults.
// ----------------------------------------------------------------------------
module encoder_position_cross_check_unit
   import epcc_pkg::*;
#(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] sample_stamp, [63:32] encoder_count, [95:64] commanded_pos_um,
   // [111:96] speed_q4
   input  logic [111:0]          req_tdata,
   // [0] homed, [1] encoder_valid
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] phase, [2] sign_negative, [26:3] measured_counts_per_mm,
   // [27] have_deviation, [59:28] deviation_um, [91:60] still_deviation_um,
   // [122:92] max_still_deviation_um, [123] lost_steps_warn, [127:124] zero
   output logic [127:0]          rsp_tdata,
   // [0] accepted
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW    = POSITION_WIDTH;
   localparam int DPW   = POSITION_WIDTH + 1;
   localparam int DEN_W = (DPW > SCALE_W) ? DPW : SCALE_W;
   localparam int SUM_W = ((NUM_W + 1 > DPW) ? NUM_W + 1 : DPW) + 1;
   localparam int CNT_W = $clog2(NUM_W);

   // Configuration registers.
   logic [15:0] still_pos_ff, still_spd_ff;
   logic [19:0] detect_ff, dev_limit_ff;
   logic [23:0] cpm_ff;
   logic [7:0]  warn_count_ff;

   // Captured beat.
   logic                     homed_ff, enc_valid_ff;
   logic [STAMP_W-1:0]       stamp_ff;
   logic [ENC_W-1:0]         enc_ff;
   logic signed [PW-1:0]     pos_ff;
   logic signed [SPEED_W-1:0] spd_ff;

   // Tracking state.
   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic                     sign_ff, sign_in;
   logic [SCALE_W-1:0]       scale_ff, scale_in;
   logic signed [DEV_W-1:0]  dev_ff, dev_in;
   logic                     have_dev_ff, have_dev_in;
   logic signed [DEV_W-1:0]  still_dev_ff, still_dev_in;
   logic [MAXDEV_W-1:0]      max_still_ff, max_still_in;
   logic                     warn_ff, warn_in;
   logic [7:0]               over_cnt_ff, over_cnt_in;
   logic [STAMP_W-1:0]       last_stamp_ff, last_stamp_in;
   logic                     have_prev_ff, have_prev_in;
   logic signed [PW-1:0]     prev_pos_ff, prev_pos_in;
   logic [STREAK_W-1:0]      streak_ff, streak_in;
   logic [ENC_W-1:0]         ref_cnt_ff, ref_cnt_in;
   logic signed [PW-1:0]     ref_pos_ff, ref_pos_in;

   // Work registers.
   logic                     accepted_ff, accepted_in;
   logic                     anchored_ff, anchored_in;
   logic signed [DPW-1:0]    dpos_ff, dpos_in;
   logic signed [ENC_W-1:0]  denc_ff, denc_in;

   // Shared divider: the numerator shifts out at the top while quotient bits
   // shift in at the bottom.
   logic [NUM_W-1:0]         nq_ff, nq_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [127:0]             rsp_data_ff, rsp_data_in;
   logic                     rsp_acc_ff, rsp_acc_in;

   // Combinational helpers.
   logic signed [DPW-1:0]    step_dpos;
   logic [DPW-1:0]           step_mag, dpos_mag;
   logic [SPEED_W-1:0]       spd_mag;
   logic                     still;
   logic [STREAK_W-1:0]      streak_next;
   logic [ENC_W-1:0]         denc_mag;
   logic [ENC_W+MM_FACTOR_W-1:0] product;
   logic [DEN_W:0]           trial, trial_diff;
   logic signed [NUM_W:0]    e_signed;
   logic signed [SUM_W-1:0]  dev_full;
   logic signed [DEV_W-1:0]  dev_sat, dev_neg;
   logic [MAXDEV_W-1:0]      dev_mag;
   logic [7:0]               over_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_acc_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         still_pos_ff  <= STILL_POS_RESET;
         still_spd_ff  <= STILL_SPD_RESET;
         detect_ff     <= DETECT_RESET;
         cpm_ff        <= CPM_RESET;
         dev_limit_ff  <= DEV_LIMIT_RESET;
         warn_count_ff <= WARN_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STILL_POS:  still_pos_ff  <= csr_wdata[15:0];
            CSR_STILL_SPD:  still_spd_ff  <= csr_wdata[15:0];
            CSR_DETECT:     detect_ff     <= csr_wdata[19:0];
            CSR_CPM:        cpm_ff        <= csr_wdata[23:0];
            CSR_DEV_LIMIT:  dev_limit_ff  <= csr_wdata[19:0];
            CSR_WARN_COUNT: warn_count_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Beat capture; the commanded position is reduced or extended to the
   // internal position width.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         homed_ff     <= req_tuser[0];
         enc_valid_ff <= req_tuser[1];
         stamp_ff     <= req_tdata[31:0];
         enc_ff       <= req_tdata[63:32];
         pos_ff       <= PW'(signed'(req_tdata[95:64]));
         spd_ff       <= signed'(req_tdata[111:96]);
      end
   end

   // Shared arithmetic, worked out from the registers of the current step.
   always_comb begin
      step_dpos   = DPW'(pos_ff) - DPW'(prev_pos_ff);
      step_mag    = step_dpos[DPW-1] ? DPW'(-step_dpos) : DPW'(step_dpos);
      spd_mag     = spd_ff[SPEED_W-1] ? SPEED_W'(-spd_ff) : SPEED_W'(spd_ff);
      still       = have_prev_ff
                    && (DEN_W'(step_mag) < DEN_W'(still_pos_ff))
                    && (spd_mag < still_spd_ff);
      streak_next = !still ? '0
                    : (streak_ff == STREAK_MAX) ? STREAK_MAX
                    : streak_ff + 1'b1;

      denc_mag    = denc_ff[ENC_W-1] ? ENC_W'(-denc_ff) : ENC_W'(denc_ff);
      dpos_mag    = dpos_ff[DPW-1] ? DPW'(-dpos_ff) : DPW'(dpos_ff);
      product     = denc_mag * MM_FACTOR;

      trial       = {rem_ff, nq_ff[NUM_W-1]};
      trial_diff  = trial - {1'b0, den_ff};

      // Encoder travel in micrometres with its direction applied.
      e_signed    = signed'({1'b0, nq_ff});
      if (denc_ff[ENC_W-1] != sign_ff) begin
         e_signed = -e_signed;
      end
      dev_full    = SUM_W'(e_signed) - SUM_W'(dpos_ff);
      if (dev_full[SUM_W-1:DEV_W-1] == '0 || dev_full[SUM_W-1:DEV_W-1] == '1) begin
         dev_sat = dev_full[DEV_W-1:0];
      end else if (dev_full[SUM_W-1]) begin
         dev_sat = {1'b1, {(DEV_W-1){1'b0}}};
      end else begin
         dev_sat = {1'b0, {(DEV_W-1){1'b1}}};
      end

      // Magnitude of the stored deviation, the most negative value capped.
      dev_neg = -dev_ff;
      if (dev_ff == {1'b1, {(DEV_W-1){1'b0}}}) begin
         dev_mag = '1;
      end else if (dev_ff[DEV_W-1]) begin
         dev_mag = dev_neg[MAXDEV_W-1:0];
      end else begin
         dev_mag = dev_ff[MAXDEV_W-1:0];
      end
      over_next = (over_cnt_ff == 8'hFF) ? over_cnt_ff : over_cnt_ff + 8'd1;
   end

   // Sequencer: next state and all register updates.
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      sign_in       = sign_ff;
      scale_in      = scale_ff;
      dev_in        = dev_ff;
      have_dev_in   = have_dev_ff;
      still_dev_in  = still_dev_ff;
      max_still_in  = max_still_ff;
      warn_in       = warn_ff;
      over_cnt_in   = over_cnt_ff;
      last_stamp_in = last_stamp_ff;
      have_prev_in  = have_prev_ff;
      prev_pos_in   = prev_pos_ff;
      streak_in     = streak_ff;
      ref_cnt_in    = ref_cnt_ff;
      ref_pos_in    = ref_pos_ff;
      accepted_in   = accepted_ff;
      anchored_in   = anchored_ff;
      dpos_in       = dpos_ff;
      denc_in       = denc_ff;
      nq_in         = nq_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_acc_in    = rsp_acc_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            accepted_in = 1'b0;
            state_in    = ST_DONE;
            if (!homed_ff || !enc_valid_ff) begin
               // Losing homing or the encoder outside the waiting phase drops everything learnt.
               if (phase_ff != PH_AWAIT) begin
                  phase_in      = PH_AWAIT;
                  sign_in       = 1'b0;
                  scale_in      = '0;
                  dev_in        = '0;
                  have_dev_in   = 1'b0;
                  still_dev_in  = '0;
                  max_still_in  = '0;
                  warn_in       = 1'b0;
                  over_cnt_in   = '0;
                  last_stamp_in = '0;
                  have_prev_in  = 1'b0;
                  prev_pos_in   = '0;
                  streak_in     = '0;
                  ref_cnt_in    = '0;
                  ref_pos_in    = '0;
               end
            end else if (stamp_ff != last_stamp_ff) begin
               accepted_in   = 1'b1;
               last_stamp_in = stamp_ff;
               streak_in     = streak_next;
               prev_pos_in   = pos_ff;
               have_prev_in  = 1'b1;
               anchored_in   = (streak_next >= STREAK_W'(2));
               dpos_in       = DPW'(pos_ff) - DPW'(ref_pos_ff);
               denc_in       = signed'(enc_ff - ref_cnt_ff);
               if (phase_ff == PH_AWAIT) begin
                  if (streak_next >= STREAK_W'(2)) begin
                     ref_cnt_in = enc_ff;
                     ref_pos_in = pos_ff;
                     phase_in   = PH_MEASURE;
                  end
               end else begin
                  state_in = ST_SCALE;
               end
            end
         end

         ST_SCALE: begin
            nq_in  = product[NUM_W-1:0];
            rem_in = '0;
            cnt_in = CNT_W'(NUM_W - 1);
            if (phase_ff == PH_MEASURE) begin
               den_in = DEN_W'(dpos_mag);
               if (anchored_ff && (DEN_W'(dpos_mag) >= DEN_W'(detect_ff))) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               // A zero scale register divides as one.
               den_in   = (cpm_ff == '0) ? DEN_W'(1) : DEN_W'(cpm_ff);
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            if (!trial_diff[DEN_W]) begin
               rem_in = trial_diff[DEN_W-1:0];
               nq_in  = {nq_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               nq_in  = {nq_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (phase_ff == PH_MEASURE) begin
               sign_in  = (denc_ff[ENC_W-1] != dpos_ff[DPW-1]);
               scale_in = (nq_ff[NUM_W-1:SCALE_W] != '0) ? SCALE_MAX
                          : nq_ff[SCALE_W-1:0];
               phase_in = PH_TRACK;
               state_in = ST_DONE;
            end else begin
               dev_in      = dev_sat;
               have_dev_in = 1'b1;
               if (anchored_ff) begin
                  still_dev_in = dev_sat;
                  state_in     = ST_STILL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_STILL: begin
            if (dev_mag > max_still_ff) begin
               max_still_in = dev_mag;
            end
            if (dev_mag > MAXDEV_W'(dev_limit_ff)) begin
               over_cnt_in = over_next;
               if (over_next >= warn_count_ff) begin
                  warn_in = 1'b1;
               end
            end else begin
               over_cnt_in = '0;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Wait until the output register is free, then load the result.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = accepted_ff;
               rsp_data_in  = {4'b0, warn_ff, max_still_ff, still_dev_ff, dev_ff,
                               have_dev_ff, scale_ff, sign_ff, phase_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_AWAIT;
         sign_ff       <= 1'b0;
         scale_ff      <= '0;
         dev_ff        <= '0;
         have_dev_ff   <= 1'b0;
         still_dev_ff  <= '0;
         max_still_ff  <= '0;
         warn_ff       <= 1'b0;
         over_cnt_ff   <= '0;
         last_stamp_ff <= '0;
         have_prev_ff  <= 1'b0;
         prev_pos_ff   <= '0;
         streak_ff     <= '0;
         ref_cnt_ff    <= '0;
         ref_pos_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         sign_ff       <= sign_in;
         scale_ff      <= scale_in;
         dev_ff        <= dev_in;
         have_dev_ff   <= have_dev_in;
         still_dev_ff  <= still_dev_in;
         max_still_ff  <= max_still_in;
         warn_ff       <= warn_in;
         over_cnt_ff   <= over_cnt_in;
         last_stamp_ff <= last_stamp_in;
         have_prev_ff  <= have_prev_in;
         prev_pos_ff   <= prev_pos_in;
         streak_ff     <= streak_in;
         ref_cnt_ff    <= ref_cnt_in;
         ref_pos_ff    <= ref_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Work and payload registers need no reset.
   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      anchored_ff <= anchored_in;
      dpos_ff     <= dpos_in;
      denc_ff     <= denc_in;
      nq_ff       <= nq_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_acc_ff  <= rsp_acc_in;
   end

`ifndef SYNTHESIS
   a_have_dev_tracking : assert property (@(posedge clock) disable iff (reset)
      have_dev_ff |-> phase_ff == PH_TRACK)
      else $error("deviation present outside tracking");

   a_scale_tracking : assert property (@(posedge clock) disable iff (reset)
      (scale_ff != '0 || sign_ff) |-> phase_ff == PH_TRACK)
      else $error("scale or sign set outside tracking");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken while one is in work");

   a_div_runs_out : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == '0) |=> state_ff == ST_FINISH)
      else $error("divider did not finish after its last step");
`endif

endmodule

// ===== tb/encoder_position_cross_check_unit_tb.sv =====
// ----------------------------------------------------------------------------
// encoder_position_cross_check_unit_tb
// Self-checking bench for the encoder position cross-check unit. Telemetry
// samples are streamed in through a queue-fed driver. A predictor of the
// tracking state computes the report for every beat the unit takes, and a monitor
// compares each report beat field by field against it. The run covers several
// register settings, including the extremes, under different idling patterns.
// ----------------------------------------------------------------------------
module encoder_position_cross_check_unit_tb;
   import epcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                      homed;
      logic                      encoder_valid;
      logic [STAMP_W-1:0]        stamp;
      logic [ENC_W-1:0]          encoder_count;
      logic signed [CMD_W-1:0]   commanded_pos;
      logic signed [SPEED_W-1:0] speed;
   } sample_t;

   typedef struct packed {
      logic                      accepted;
      phase_type                 phase;
      logic                      sign_negative;
      logic [SCALE_W-1:0]        counts_per_mm;
      logic                      have_deviation;
      logic signed [DEV_W-1:0]   deviation;
      logic signed [DEV_W-1:0]   still_deviation;
      logic [MAXDEV_W-1:0]       max_still;
      logic                      warn;
   } report_t;

   localparam longint DEV_HI = 2147483647;
   localparam longint DEV_LO = -DEV_HI - 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [111:0]          req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [127:0]          rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   encoder_position_cross_check_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   sample_t pending_samples[$];
   report_t expected_reports[$];
   sample_t in_flight;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatches         = 0;
   int reports_checked    = 0;
   int accepted_seen      = 0;
   int tracking_seen      = 0;
   int warn_seen          = 0;
   int settings_used      = 1;
   int queued_count       = 0;
   logic [31:0] stamp_ctr = '0;
   logic [31:0] last_queued_stamp = '0;

   // Register copies as the predictor sees them.
   longint cfg_still_pos   = STILL_POS_RESET;
   longint cfg_still_speed = STILL_SPD_RESET;
   longint cfg_detect      = DETECT_RESET;
   longint cfg_cpm         = CPM_RESET;
   longint cfg_dev_limit   = DEV_LIMIT_RESET;
   longint cfg_warn_count  = WARN_COUNT_RESET;

   // Tracking state of the predictor.
   phase_type               cur_phase;
   logic                    sign_neg;
   logic [SCALE_W-1:0]      scale;
   logic signed [DEV_W-1:0] deviation;
   logic signed [DEV_W-1:0] still_dev;
   logic                    have_dev;
   logic [MAXDEV_W-1:0]     max_still;
   logic                    warn;
   logic [7:0]              over_count;
   logic [STAMP_W-1:0]      last_stamp;
   logic                    have_prev;
   logic signed [CMD_W-1:0] prev_pos;
   logic [STREAK_W-1:0]     streak;
   logic [ENC_W-1:0]        ref_count;
   logic signed [CMD_W-1:0] ref_pos;

   // Session state of the stimulus generator: an axis with a true scale.
   longint sess_pos, sess_base_pos, sess_base_enc, sess_cpm, sess_slip, sess_dir;

   function automatic longint mag(longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic longint spread(longint lim);
      return longint'($urandom_range(32'(2 * lim))) - lim;
   endfunction

   function automatic void clear_tracking();
      cur_phase  = PH_AWAIT;
      sign_neg   = 1'b0;
      scale      = '0;
      deviation  = '0;
      still_dev  = '0;
      have_dev   = 1'b0;
      max_still  = '0;
      warn       = 1'b0;
      over_count = '0;
      last_stamp = '0;
      have_prev  = 1'b0;
      prev_pos   = '0;
      streak     = '0;
      ref_count  = '0;
      ref_pos    = '0;
   endfunction

   function automatic report_t predict_report(input sample_t s);
      report_t     r;
      longint      pos, spd, d_pos, d_enc, enc_um, dev, m, q;
      logic [31:0] enc_diff;
      bit          still, anchored;
      r = '0;
      if (!s.homed || !s.encoder_valid) begin
         if (cur_phase != PH_AWAIT) clear_tracking();
      end else if (s.stamp != last_stamp) begin
         last_stamp = s.stamp;
         r.accepted = 1'b1;
         pos = longint'(s.commanded_pos);
         spd = longint'(s.speed);
         still = have_prev && mag(pos - longint'(prev_pos)) < cfg_still_pos &&
                 mag(spd) < cfg_still_speed;
         if (!still) streak = '0;
         else if (streak != STREAK_MAX) streak++;
         prev_pos  = s.commanded_pos;
         have_prev = 1'b1;
         anchored  = (streak >= 2);
         enc_diff  = s.encoder_count - ref_count;
         d_enc     = longint'($signed(enc_diff));
         d_pos     = pos - longint'(ref_pos);
         case (cur_phase)
            PH_AWAIT: begin
               if (anchored) begin
                  ref_count = s.encoder_count;
                  ref_pos   = s.commanded_pos;
                  cur_phase = PH_MEASURE;
               end
            end
            PH_MEASURE: begin
               if (anchored && mag(d_pos) >= cfg_detect) begin
                  q = (d_pos == 0) ? longint'(SCALE_MAX) :
                      mag(d_enc) * longint'(MM_FACTOR) / mag(d_pos);
                  sign_neg  = ((d_enc >= 0) != (d_pos >= 0));
                  scale     = (q > longint'(SCALE_MAX)) ? SCALE_MAX : q[SCALE_W-1:0];
                  cur_phase = PH_TRACK;
               end
            end
            default: begin
               enc_um = mag(d_enc) * longint'(MM_FACTOR) / ((cfg_cpm == 0) ? 1 : cfg_cpm);
               if ((d_enc < 0) != sign_neg) enc_um = -enc_um;
               dev = enc_um - d_pos;
               if (dev > DEV_HI) dev = DEV_HI;
               else if (dev < DEV_LO) dev = DEV_LO;
               deviation = 32'(dev);
               have_dev  = 1'b1;
               if (anchored) begin
                  still_dev = 32'(dev);
                  m = mag(dev);
                  if (m > DEV_HI) m = DEV_HI;
                  if (m > longint'(max_still)) max_still = 31'(m);
                  if (m > cfg_dev_limit) begin
                     if (over_count != 8'hFF) over_count++;
                     if (over_count >= cfg_warn_count) warn = 1'b1;
                  end else begin
                     over_count = '0;
                  end
               end
            end
         endcase
      end
      r.phase           = cur_phase;
      r.sign_negative   = sign_neg;
      r.counts_per_mm   = scale;
      r.have_deviation  = have_dev;
      r.deviation       = deviation;
      r.still_deviation = still_dev;
      r.max_still       = max_still;
      r.warn            = warn;
      return r;
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Driver: a new beat may be offered once the previous one has gone, unless the sender idles.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(predict_report(in_flight));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               in_flight = pending_samples.pop_front();
               req_tdata <= {in_flight.speed, in_flight.commanded_pos,
                             in_flight.encoder_count, in_flight.stamp};
               req_tuser <= {in_flight.encoder_valid, in_flight.homed};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every report beat is matched against the oldest prediction.
   always @(posedge clock) begin : report_monitor
      report_t seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.accepted        = rsp_tuser[0];
            seen.phase           = phase_type'(rsp_tdata[1:0]);
            seen.sign_negative   = rsp_tdata[2];
            seen.counts_per_mm   = rsp_tdata[26:3];
            seen.have_deviation  = rsp_tdata[27];
            seen.deviation       = rsp_tdata[59:28];
            seen.still_deviation = rsp_tdata[91:60];
            seen.max_still       = rsp_tdata[122:92];
            seen.warn            = rsp_tdata[123];
            if (expected_reports.size() == 0) begin
               $error("report beat arrived with no prediction waiting");
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("accepted", want.accepted, seen.accepted);
               check_field("phase", want.phase, seen.phase);
               check_field("sign_negative", want.sign_negative, seen.sign_negative);
               check_field("measured_counts_per_mm", want.counts_per_mm, seen.counts_per_mm);
               check_field("have_deviation", want.have_deviation, seen.have_deviation);
               check_field("deviation_um", want.deviation, seen.deviation);
               check_field("still_deviation_um", want.still_deviation, seen.still_deviation);
               check_field("max_still_deviation_um", want.max_still, seen.max_still);
               check_field("lost_steps_warn", want.warn, seen.warn);
               reports_checked++;
               if (want.accepted) accepted_seen++;
               if (want.phase == PH_TRACK) tracking_seen++;
               if (want.warn) warn_seen++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic logic [31:0] next_stamp();
      if ($urandom_range(19) == 0) stamp_ctr = $urandom;
      else stamp_ctr = stamp_ctr + $urandom_range(4, 1);
      return stamp_ctr;
   endfunction

   function automatic void add_sample(logic homed, logic ev, logic [31:0] stamp,
                                      logic [31:0] enc, logic [31:0] pos,
                                      logic [15:0] spd);
      pending_samples.push_back('{homed, ev, stamp, enc, pos, spd});
      // Beats that the unit ignores are not counted.
      if (homed && ev && stamp != last_queued_stamp) queued_count++;
      last_queued_stamp = stamp;
   endfunction

   function automatic longint still_step();
      longint lim;
      lim = (cfg_still_pos > 2000) ? 2000 : cfg_still_pos - 1;
      return (lim > 0) ? spread(lim) : 0;
   endfunction

   function automatic void axis_sample(longint step, bit moving);
      longint spd, enc, lim;
      sess_pos += step;
      if (moving) begin
         if (cfg_still_speed <= 32767)
            spd = longint'($urandom_range(32767, 32'(cfg_still_speed)));
         else
            spd = longint'($urandom_range(32767));
         if ($urandom_range(1)) spd = -spd;
      end else begin
         lim = (cfg_still_speed > 32768) ? 32767 : cfg_still_speed - 1;
         spd = (lim > 0) ? spread(lim) : 0;
      end
      enc = sess_base_enc + sess_dir * (sess_pos - sess_base_pos) * sess_cpm /
            longint'(MM_FACTOR) + sess_slip;
      add_sample(1'b1, 1'b1, next_stamp(), 32'(enc), 32'(sess_pos), 16'(spd));
   endfunction

   // A well-formed run: settle, travel past the detect distance, settle, then
   // track with moves and encoder slips. Some runs are cut by a homing or encoder loss.
   function automatic void queue_session();
      longint travel, part, slip;
      int     steps, n;
      logic   homed;
      sess_pos      = spread(longint'(1) << 30);
      sess_base_pos = sess_pos;
      sess_base_enc = $urandom;
      sess_dir      = $urandom_range(1) ? 1 : -1;
      sess_cpm      = cfg_cpm + spread(cfg_cpm / 8);
      if (sess_cpm < 1) sess_cpm = 1;
      sess_slip     = 0;
      repeat ($urandom_range(5, 3)) axis_sample(still_step(), 1'b0);
      travel = cfg_detect + longint'($urandom_range(32'(cfg_detect / 2)));
      if ($urandom_range(1)) travel = -travel;
      steps = $urandom_range(3, 1);
      part  = travel / steps;
      for (int i = 0; i < steps; i++)
         axis_sample((i == steps - 1) ? travel - part * (steps - 1) : part, 1'b1);
      repeat ($urandom_range(4, 3)) axis_sample(still_step(), 1'b0);
      n = $urandom_range(24, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(99)) inside
            [0:6]: begin
               homed = $urandom_range(1);
               add_sample(homed, homed ? 1'b0 : 1'(($urandom_range(1))), next_stamp(),
                          $urandom, 32'(sess_pos), '0);
               break;
            end
            [7:21]: axis_sample(spread(5000), 1'b1);
            [22:34]: begin
               // Encoder slip: mostly well past the deviation limit.
               slip = (cfg_dev_limit + longint'($urandom_range(32'(cfg_dev_limit), 1))) *
                      sess_cpm / longint'(MM_FACTOR) + 1;
               sess_slip = $urandom_range(3) == 0 ? spread(2) :
                           ($urandom_range(1) ? slip : -slip);
               axis_sample(still_step(), 1'b0);
            end
            default: axis_sample(still_step(), 1'b0);
         endcase
      end
   endfunction

   function automatic void queue_noise(int count);
      logic [31:0] st;
      repeat (count) begin
         st = ($urandom_range(3) == 0) ? stamp_ctr : next_stamp();
         add_sample($urandom_range(9) != 0, $urandom_range(9) != 0, st, $urandom,
                    $urandom, 16'($urandom));
      end
   endfunction

   function automatic void queue_random(int count);
      int start;
      start = queued_count;
      while (queued_count - start < count) begin
         if ($urandom_range(99) < 80) queue_session();
         else queue_noise($urandom_range(5, 1));
      end
   endfunction

   task automatic drain_results();
      while (pending_samples.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, longint value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (index)
         CSR_STILL_POS:  cfg_still_pos   = value;
         CSR_STILL_SPD:  cfg_still_speed = value;
         CSR_DETECT:     cfg_detect      = value;
         CSR_CPM:        cfg_cpm         = value;
         CSR_DEV_LIMIT:  cfg_dev_limit   = value;
         CSR_WARN_COUNT: cfg_warn_count  = value;
         default: ;
      endcase
   endtask

   task automatic set_config(longint sp, longint ss, longint dd, longint cpm,
                             longint dl, longint wc);
      write_reg(CSR_STILL_POS, sp);
      write_reg(CSR_STILL_SPD, ss);
      write_reg(CSR_DETECT, dd);
      write_reg(CSR_CPM, cpm);
      write_reg(CSR_DEV_LIMIT, dl);
      write_reg(CSR_WARN_COUNT, wc);
      settings_used++;
   endtask

   // The sender holds off halfway through until every report is back.
   task automatic run_phase(int count);
      queue_random(count / 2);
      drain_results();
      queue_random(count - count / 2);
      drain_results();
   endtask

   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      clear_tracking();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Register defaults, no idling. The directed beats walk through the
      // phases with exact values, field extremes and the clearing cases.
      add_sample(1'b0, 1'b0, '1, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000);
      add_sample(1'b1, 1'b1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
      add_sample(1'b1, 1'b0, 32'd1, 32'd0, 32'd0, 16'd0);
      add_sample(1'b1, 1'b1, '1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
      add_sample(1'b1, 1'b1, 32'd1, 32'd100, 32'd1000, 16'd0);
      add_sample(1'b1, 1'b1, 32'd2, 32'd100, 32'd1049, -16'sd47);
      add_sample(1'b1, 1'b1, 32'd3, 32'd100, 32'd1000, 16'd47);
      add_sample(1'b1, 1'b1, 32'd3, 32'd555, 32'd0, 16'd0);
      add_sample(1'b1, 1'b1, 32'd4, 32'd500, 32'd5000, 16'd2000);
      add_sample(1'b1, 1'b1, 32'd5, 32'd901, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd6, 32'd901, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd7, 32'd901, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd8, 32'h8000_0063, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd9, 32'h8000_0064, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd10, 32'h8000_0064, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd11, 32'd901, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd12, 32'd0, 32'h8000_0000, 16'h8000);
      add_sample(1'b1, 1'b1, 32'd12, 32'd7, 32'd9, 16'd1);
      add_sample(1'b1, 1'b0, 32'd13, 32'd901, 32'd9010, 16'd0);
      add_sample(1'b1, 1'b1, 32'd14, 32'd5, 32'd7, 16'd3);
      add_sample(1'b0, 1'b1, 32'd15, 32'd5, 32'd7, 16'd3);
      run_phase(180);

      set_config(120, 200, 3000, 51200, 400, 4);
      sender_idle_pct    = 78;
      receiver_stall_pct = 0;
      run_phase(220);

      // Everything is still and every deviation is over the limit.
      set_config(65535, 65535, 1, 1, 1, 1);
      sender_idle_pct    = 0;
      receiver_stall_pct = 78;
      run_phase(150);

      set_config(1, 1, 1000000, 16777215, 1000000, 255);
      sender_idle_pct    = 34;
      receiver_stall_pct = 34;
      run_phase(150);

      // No sample can ever be still.
      set_config(0, 0, 500, 25600, 1000, 3);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_phase(60);

      repeat (3) begin
         set_config($urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(300),
                    $urandom_range(400), $urandom_range(50000, 1),
                    $urandom_range(1) ? $urandom_range(200000, 256) :
                                        $urandom_range(16777215, 1),
                    $urandom_range(5000, 1), $urandom_range(8, 1));
         case ($urandom_range(3))
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
            default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
         endcase
         run_phase(110);
      end

      $display("Checked %0d report beats under %0d register settings: %0d accepted samples,",
               reports_checked, settings_used, accepted_seen);
      $display("%0d reports in tracking and %0d with the lost-steps warning latched.",
               tracking_seen, warn_seen);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
